@@ sv/prrm_pkg.sv @@
// shared constants and types for the pixel row repeat-mask compactor
// no dependencies; imported by the interfaces and every module of the block
package prrm_pkg;

	localparam int LANES              = 8;
	localparam int PIXEL_W            = 32;
	localparam int COUNT_W            = 4;
	localparam int OFFSET_W           = 9;
	localparam int ROW_PIXELS_DEFAULT = 256;

	typedef logic [PIXEL_W-1:0]  pixel_t;
	typedef pixel_t [LANES-1:0]  pixel_vec_t;
	typedef logic [LANES-1:0]    mask_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [OFFSET_W-1:0] offset_t;

	// status that travels with the packed pixels out of the compaction unit
	typedef struct packed {
		mask_t  same_mask;
		count_t kept_count;
	} cmp_stat_t;

endpackage

@@ sv/prrm_pix_if.sv @@
// input channel: one group of eight pixels per transaction
// depends on prrm_pkg
interface prrm_pix_if import prrm_pkg::*; ();
	logic   valid;
	logic   ready;
	pixel_t pixel_0;
	pixel_t pixel_1;
	pixel_t pixel_2;
	pixel_t pixel_3;
	pixel_t pixel_4;
	pixel_t pixel_5;
	pixel_t pixel_6;
	pixel_t pixel_7;

	modport source (
		output valid, pixel_0, pixel_1, pixel_2, pixel_3,
		       pixel_4, pixel_5, pixel_6, pixel_7,
		input  ready
	);
	modport sink (
		input  valid, pixel_0, pixel_1, pixel_2, pixel_3,
		       pixel_4, pixel_5, pixel_6, pixel_7,
		output ready
	);
endinterface

@@ sv/prrm_res_if.sv @@
// result channel: packed pixels, repeat mask, count, offset and row end
// depends on prrm_pkg
interface prrm_res_if import prrm_pkg::*; ();
	logic    valid;
	logic    ready;
	pixel_t  kept_0;
	pixel_t  kept_1;
	pixel_t  kept_2;
	pixel_t  kept_3;
	pixel_t  kept_4;
	pixel_t  kept_5;
	pixel_t  kept_6;
	pixel_t  kept_7;
	mask_t   same_mask;
	count_t  kept_count;
	offset_t row_offset;
	logic    row_done;

	modport source (
		output valid, kept_0, kept_1, kept_2, kept_3, kept_4, kept_5, kept_6, kept_7,
		       same_mask, kept_count, row_offset, row_done,
		input  ready
	);
	modport sink (
		input  valid, kept_0, kept_1, kept_2, kept_3, kept_4, kept_5, kept_6, kept_7,
		       same_mask, kept_count, row_offset, row_done,
		output ready
	);
endinterface

@@ sv/prrm_compact.sv @@
// combinational repeat detection and stream compaction of one pixel group
// depends on prrm_pkg
module prrm_compact import prrm_pkg::*; (
	input  pixel_t     prev,
	input  pixel_vec_t pix,
	output pixel_vec_t kept,
	output cmp_stat_t  stat
);

	mask_t  same;
	count_t pos [LANES];
	count_t total;

	// lane 0 looks at the carried pixel, the others at their left neighbor
	always_comb begin
		same[0] = (pix[0] == prev);
		for (int i = 1; i < LANES; i++) begin
			same[i] = (pix[i] == pix[i-1]);
		end
	end

	// slot each kept lane lands in
	always_comb begin
		count_t acc;
		acc = '0;
		for (int i = 0; i < LANES; i++) begin
			pos[i] = acc;
			acc    = acc + count_t'(!same[i]);
		end
		total = acc;
	end

	// unused slots fall back to lane 0
	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			kept[j] = pix[0];
			for (int i = 0; i < LANES; i++) begin
				if (!same[i] && (pos[i] == count_t'(j))) begin
					kept[j] = pix[i];
				end
			end
		end
	end

	assign stat.same_mask  = same;
	assign stat.kept_count = total;

endmodule

@@ sv/pixel_row_repeat_mask_compactor.sv @@
// top level of the pixel row repeat-mask compactor: input register, compaction, result register
// depends on prrm_pkg, prrm_pix_if, prrm_res_if and prrm_compact
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+----------------------------------------------------
//  pixels   | in  | valid / ready | pixel_0 .. pixel_7 (32 bit each)
//  result   | out | valid / ready | kept_0 .. kept_7, same_mask, kept_count,
//           |     |               | row_offset, row_done
//
// one group enters per cycle while the result side keeps ready high; its result passes through
// the input register, then compare-and-pack logic into the result register
// throughput is one transaction per cycle while the result side keeps ready high
// arst_n clears the valid flags, the carried pixel, the group counter and the row offset
// a stalled result holds in its register; the input register still takes one more group,
// then pixels.ready drops until the result is taken
module pixel_row_repeat_mask_compactor import prrm_pkg::*; #(
	parameter int ROW_PIXELS = ROW_PIXELS_DEFAULT
) (
	input logic          clk,
	input logic          arst_n,
	prrm_pix_if.sink     pixels,
	prrm_res_if.source   result
);

	localparam int GROUPS = ROW_PIXELS / LANES;
	localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

	typedef logic [GRP_W-1:0] grp_t;

	// input stage
	logic       valid_s1;
	pixel_vec_t pix_s1;

	// row state, advanced when a group leaves the input stage
	pixel_t  prev_q;
	grp_t    grp_q;
	offset_t kept_so_far_q;

	// result stage
	logic       valid_s2;
	pixel_vec_t kept_s2;
	mask_t      mask_s2;
	count_t     count_s2;
	offset_t    offset_s2;
	logic       done_s2;

	pixel_vec_t kept_c;
	cmp_stat_t  stat_c;
	logic       last_c;
	logic       advance;

	// group moves on when the result register is free or being drained
	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign pixels.ready = !valid_s1 || advance;
	assign last_c       = (grp_q >= grp_t'(GROUPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixels.ready) begin
			valid_s1 <= pixels.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (pixels.valid && pixels.ready) begin
			pix_s1[0] <= pixels.pixel_0;
			pix_s1[1] <= pixels.pixel_1;
			pix_s1[2] <= pixels.pixel_2;
			pix_s1[3] <= pixels.pixel_3;
			pix_s1[4] <= pixels.pixel_4;
			pix_s1[5] <= pixels.pixel_5;
			pix_s1[6] <= pixels.pixel_6;
			pix_s1[7] <= pixels.pixel_7;
		end
	end

	prrm_compact u_compact (
		.prev (prev_q),
		.pix  (pix_s1),
		.kept (kept_c),
		.stat (stat_c)
	);

	// row bookkeeping: the last group of a row returns everything to the row-start values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q        <= '0;
			grp_q         <= '0;
			kept_so_far_q <= '0;
		end else if (advance) begin
			if (last_c) begin
				prev_q        <= '0;
				grp_q         <= '0;
				kept_so_far_q <= '0;
			end else begin
				prev_q        <= pix_s1[LANES-1];
				grp_q         <= grp_q + grp_t'(1);
				kept_so_far_q <= kept_so_far_q + offset_t'(stat_c.kept_count);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kept_s2   <= kept_c;
			mask_s2   <= stat_c.same_mask;
			count_s2  <= stat_c.kept_count;
			offset_s2 <= kept_so_far_q;
			done_s2   <= last_c;
		end
	end

	assign result.valid      = valid_s2;
	assign result.kept_0     = kept_s2[0];
	assign result.kept_1     = kept_s2[1];
	assign result.kept_2     = kept_s2[2];
	assign result.kept_3     = kept_s2[3];
	assign result.kept_4     = kept_s2[4];
	assign result.kept_5     = kept_s2[5];
	assign result.kept_6     = kept_s2[6];
	assign result.kept_7     = kept_s2[7];
	assign result.same_mask  = mask_s2;
	assign result.kept_count = count_s2;
	assign result.row_offset = offset_s2;
	assign result.row_done   = done_s2;

	// every lane is either a repeat or a kept pixel
	a_count_matches_mask: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ($countones(result.same_mask) + int'(result.kept_count) == LANES))
		else $error("kept_count disagrees with same_mask");

	// closing a row leaves the row state at its start values
	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_c) |=> (grp_q == '0 && kept_so_far_q == '0 && prev_q == '0))
		else $error("row state not cleared after last group");

	// input only stalls while a group is held back by a full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pixels.ready |-> (valid_s1 && valid_s2 && !result.ready))
		else $error("input stalled without a blocked group");

	// a group that moves on shows up as a result in the next cycle
	a_advance_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (valid_s2 && result.row_done == $past(last_c)))
		else $error("advanced group missing from result register");

endmodule
